// ----- sv/deq_pkg.sv -----
`default_nettype none
package deq_pkg;

    // Storage geometry
    localparam int DEPTH      = 64;
    localparam int WORD_BITS  = 32;
    localparam int PTR_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_BITS = $clog2(DEPTH + 1);
    localparam int POS_BITS   = 6;
    localparam int CMP_BITS   = (POS_BITS > COUNT_BITS) ? POS_BITS : COUNT_BITS;
    localparam int SUM_BITS   = COUNT_BITS + 1;

    // Request opcodes
    typedef enum logic [2:0] {
        OP_PUSH_TAIL = 3'd0,
        OP_PUSH_HEAD = 3'd1,
        OP_POP_TAIL  = 3'd2,
        OP_POP_HEAD  = 3'd3,
        OP_READ      = 3'd4
    } t_opcode;

    // Response status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY_POP = 2'd2,
        ST_RANGE     = 2'd3
    } t_status;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic latch_req;
        logic execute;
        logic load_out;
    } t_deq_cmd;

    // Ring index: (base + off) mod DEPTH, with base < DEPTH and off <= DEPTH
    function automatic logic [PTR_BITS-1:0] ring_add(
        input logic [PTR_BITS-1:0]   base,
        input logic [COUNT_BITS-1:0] off
    );
        logic [SUM_BITS-1:0] sum;
        sum = SUM_BITS'(base) + SUM_BITS'(off);
        if (sum >= SUM_BITS'(DEPTH)) begin
            sum = sum - SUM_BITS'(DEPTH);
        end
        return sum[PTR_BITS-1:0];
    endfunction

endpackage
`default_nettype wire

// ----- sv/deq_if.sv -----
`default_nettype none
// Request channel
interface deq_req_if;
    logic                          valid;
    logic                          ready;
    logic [2:0]                    opcode;
    logic signed [31:0]            data_word;
    logic [5:0]                    position;

    modport source (output valid, output opcode, output data_word, output position,
                    input ready);
    modport sink   (input valid, input opcode, input data_word, input position,
                    output ready);
endinterface

// Response channel
interface deq_rsp_if;
    logic                          valid;
    logic                          ready;
    logic signed [31:0]            read_word;
    logic [6:0]                    count;
    logic                          is_empty;
    logic [1:0]                    status;

    modport source  (output valid, output read_word, output count, output is_empty,
                     output status, input ready);
    modport sink    (input valid, input read_word, input count, input is_empty,
                     input status, output ready);
    modport monitor (input valid, input ready, input read_word, input count,
                     input is_empty, input status);
endinterface
`default_nettype wire

// ----- sv/deq_ctrl.sv -----
`default_nettype none
module deq_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_req_valid,
    output logic              o_req_ready,
    input  wire               i_rsp_ready,
    output logic              o_rsp_valid,
    output deq_pkg::t_deq_cmd o_cmd
);
    import deq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_rsp_valid, n_rsp_valid;
    logic   w_accept;
    logic   w_load;

    assign o_req_ready = (r_state == S_IDLE);
    assign w_accept    = i_req_valid && o_req_ready;
    // result register is free when empty or drained this cycle
    assign w_load      = (r_state == S_DONE) && (!r_rsp_valid || i_rsp_ready);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_accept) n_state = S_EXEC;
            S_EXEC: n_state = S_DONE;
            S_DONE: if (w_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // response valid flag
    always_comb begin
        n_rsp_valid = r_rsp_valid;
        if (r_rsp_valid && i_rsp_ready) n_rsp_valid = 1'b0;
        if (w_load) n_rsp_valid = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    assign o_rsp_valid     = r_rsp_valid;
    assign o_cmd.latch_req = w_accept;
    assign o_cmd.execute   = (r_state == S_EXEC);
    assign o_cmd.load_out  = w_load;
endmodule
`default_nettype wire

// ----- sv/deq_datapath.sv -----
`default_nettype none
module deq_datapath (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    input  deq_pkg::t_deq_cmd                      i_cmd,
    input  wire  [2:0]                             i_opcode,
    input  wire  signed [deq_pkg::WORD_BITS-1:0]   i_data_word,
    input  wire  [deq_pkg::POS_BITS-1:0]           i_position,
    output logic signed [deq_pkg::WORD_BITS-1:0]   o_read_word,
    output logic [deq_pkg::COUNT_BITS-1:0]         o_count,
    output logic                                   o_is_empty,
    output logic [1:0]                             o_status
);
    import deq_pkg::*;

    // slot storage, no reset
    logic [WORD_BITS-1:0] mem [DEPTH];

    // request registers
    logic [2:0]           r_op;
    logic [WORD_BITS-1:0] r_word;
    logic [POS_BITS-1:0]  r_pos;

    // queue state
    logic [PTR_BITS-1:0]   r_front, n_front;
    logic [COUNT_BITS-1:0] r_count, n_count;

    // execute results
    t_status              r_status, n_status;
    logic                 r_rd_ok, n_rd_ok;
    logic [WORD_BITS-1:0] r_mem_q;

    logic                  w_we;
    logic [PTR_BITS-1:0]   w_waddr;
    logic [PTR_BITS-1:0]   w_raddr;
    logic                  w_full;
    logic                  w_empty;
    logic                  w_in_range;
    logic [CMP_BITS-1:0]   w_pos_ext;

    assign w_full     = (r_count == COUNT_BITS'(DEPTH));
    assign w_empty    = (r_count == '0);
    assign w_pos_ext  = CMP_BITS'(r_pos);
    assign w_in_range = (w_pos_ext < CMP_BITS'(r_count));
    // only used when in range, so position fits the count width
    assign w_raddr    = ring_add(r_front, w_pos_ext[COUNT_BITS-1:0]);

    // operation decode
    always_comb begin
        n_front  = r_front;
        n_count  = r_count;
        n_status = ST_OK;
        n_rd_ok  = 1'b0;
        w_we     = 1'b0;
        w_waddr  = ring_add(r_front, r_count);
        unique case (r_op)
            OP_PUSH_TAIL: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    w_we    = 1'b1;
                    n_count = r_count + COUNT_BITS'(1);
                end
            end
            OP_PUSH_HEAD: begin
                w_waddr = ring_add(r_front, COUNT_BITS'(DEPTH - 1));
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    w_we    = 1'b1;
                    n_front = w_waddr;
                    n_count = r_count + COUNT_BITS'(1);
                end
            end
            OP_POP_TAIL: begin
                if (w_empty) n_status = ST_EMPTY_POP;
                else         n_count  = r_count - COUNT_BITS'(1);
            end
            OP_POP_HEAD: begin
                if (w_empty) begin
                    n_status = ST_EMPTY_POP;
                end else begin
                    n_front = ring_add(r_front, COUNT_BITS'(1));
                    n_count = r_count - COUNT_BITS'(1);
                end
            end
            OP_READ: begin
                if (w_in_range) n_rd_ok  = 1'b1;
                else            n_status = ST_RANGE;
            end
            default: ;
        endcase
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_req) begin
            r_op   <= i_opcode;
            r_word <= i_data_word;
            r_pos  <= i_position;
        end
    end

    // slot write and registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.execute) begin
            if (w_we) mem[w_waddr] <= r_word;
            r_mem_q <= mem[w_raddr];
        end
    end

    // pointer and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_count <= '0;
        end else if (i_cmd.execute) begin
            r_front <= n_front;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.execute) begin
            r_status <= n_status;
            r_rd_ok  <= n_rd_ok;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_read_word <= r_rd_ok ? r_mem_q : '0;
            o_count     <= r_count;
            o_is_empty  <= w_empty;
            o_status    <= r_status;
        end
    end
endmodule
`default_nettype wire

// ----- sv/double_ended_queue_top.sv -----
`default_nettype none
// Bounded double-ended queue of 64 signed 32-bit words in a ring buffer.
// i_req carries one request per transaction: opcode (push back, push front,
// pop back, pop front, read), data_word for pushes, position for reads.
// o_rsp returns one transaction per request: read_word (zero unless a read
// succeeds), count after the request, is_empty and status (ok, full push
// refused, pop of an empty queue, read position out of range).
// Each request passes through capture, execute (slot write and registered
// slot read, pointer and count update) and result load, in that order. A new
// request is accepted only once the previous one has reached the result load.
// The result register decouples the channels: while a response waits on
// o_rsp.ready the next request is still accepted and executed, then holds
// before the result load until the response register frees up.
// Reset (synchronous, active low) empties the queue, clears the response
// valid flag and returns the controller to idle; slot contents are not
// cleared and are only read once written.
module double_ended_queue_top (
    input  wire      i_clk,
    input  wire      i_rst_n,
    deq_req_if.sink  i_req,
    deq_rsp_if.source o_rsp
);
    import deq_pkg::*;

    t_deq_cmd w_cmd;

    deq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_rsp_ready (o_rsp.ready),
        .o_rsp_valid (o_rsp.valid),
        .o_cmd       (w_cmd)
    );

    deq_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_opcode    (i_req.opcode),
        .i_data_word (i_req.data_word),
        .i_position  (i_req.position),
        .o_read_word (o_rsp.read_word),
        .o_count     (o_rsp.count),
        .o_is_empty  (o_rsp.is_empty),
        .o_status    (o_rsp.status)
    );
endmodule
`default_nettype wire

// ----- sv/deq_checker.sv -----
`default_nettype none
module deq_checker (
    input wire                                  i_clk,
    input wire                                  i_rst_n,
    input wire                                  i_valid,
    input wire                                  i_ready,
    input wire signed [deq_pkg::WORD_BITS-1:0]  i_read_word,
    input wire [deq_pkg::COUNT_BITS-1:0]        i_count,
    input wire                                  i_is_empty,
    input wire [1:0]                            i_status
);
    import deq_pkg::*;

    // empty flag tracks the count
    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (i_is_empty == (i_count == '0)))
        else $error("is_empty disagrees with count");

    // refused push only when full
    a_full_refuse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_status == ST_FULL) |-> (i_count == COUNT_BITS'(DEPTH)))
        else $error("full status with room left");

    // failed pop only when empty
    a_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_status == ST_EMPTY_POP) |-> i_is_empty)
        else $error("empty pop status on a non-empty queue");

    // failed requests never return data
    a_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_status != ST_OK) |-> (i_read_word == '0))
        else $error("read_word set on a failed request");

    // stalled response holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_ready) |=>
            (i_valid && $stable(i_count) && $stable(i_status)
             && $stable(i_read_word)))
        else $error("response changed while stalled");
endmodule

bind double_ended_queue_top deq_checker u_deq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (o_rsp.valid),
    .i_ready     (o_rsp.ready),
    .i_read_word (o_rsp.read_word),
    .i_count     (o_rsp.count),
    .i_is_empty  (o_rsp.is_empty),
    .i_status    (o_rsp.status)
);
`default_nettype wire

// ----- tb/double_ended_queue_top_tb.sv -----
`timescale 1ns / 100ps
module double_ended_queue_top_tb;
    import deq_pkg::*;

    localparam int          CLK_HALF       = 6;
    localparam int          RESET_CYCLES   = 9;
    localparam int          RANDOM_ITEMS   = 1880;
    localparam int          IDLE_PERCENT   = 15;
    localparam int          QUIET_FIRST    = 2000;
    localparam int          QUIET_LAST     = 3500;
    localparam int          HOLD_AT_RSP    = 500;
    localparam int          HOLD_CYCLES    = 300;
    localparam int          WATCHDOG_LIMIT = 3000;
    localparam int          DRAIN_CYCLES   = 12;
    localparam int          PRINT_CAP      = 40;
    // Opcodes the block does not decode
    localparam logic [2:0]  OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0]  OP_SPARE_LAST  = 3'd7;

    typedef struct {
        logic [2:0]                  opcode;
        logic signed [WORD_BITS-1:0] data_word;
        logic [POS_BITS-1:0]         position;
    } t_deq_request;

    typedef struct {
        logic signed [WORD_BITS-1:0] read_word;
        logic [COUNT_BITS-1:0]       count;
        logic                        is_empty;
        t_status                     status;
    } t_deq_answer;

    typedef enum int {MODE_FILL, MODE_DRAIN, MODE_BALANCED, MODE_READS} t_mix_mode;

    logic i_clk;
    logic i_rst_n;

    deq_req_if req_ch();
    deq_rsp_if rsp_ch();

    double_ended_queue_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // Shadow deque state
    logic signed [WORD_BITS-1:0] ring_mem [DEPTH];
    logic [PTR_BITS-1:0]         head_idx;
    logic [COUNT_BITS-1:0]       occupancy;

    t_deq_request request_backlog[$];
    t_deq_answer  expected_answers[$];
    int           gen_fill;
    int           err_cnt;
    int           rsp_seen;
    int           hold_left;
    bit           hold_done;
    int           cyc;
    int           stall_cycles;

    // Clock
    initial i_clk = 1'b0;
    always #CLK_HALF i_clk = ~i_clk;

    task automatic note_error(input string msg);
        if (err_cnt < PRINT_CAP) begin
            $display("ERROR at %0t: %s", $time, msg);
        end
        err_cnt++;
    endtask

    // Apply one request to the shadow deque and return the answer it earns
    function automatic t_deq_answer deque_model_apply(input t_deq_request rq);
        t_deq_answer ans;
        int          slot;
        ans.read_word = '0;
        ans.status    = ST_OK;
        case (rq.opcode)
            OP_PUSH_TAIL: begin
                if (occupancy >= DEPTH) begin
                    ans.status = ST_FULL;
                end else begin
                    slot = (int'(head_idx) + int'(occupancy)) % DEPTH;
                    ring_mem[slot] = rq.data_word;
                    occupancy++;
                end
            end
            OP_PUSH_HEAD: begin
                if (occupancy >= DEPTH) begin
                    ans.status = ST_FULL;
                end else begin
                    head_idx = PTR_BITS'((int'(head_idx) + DEPTH - 1) % DEPTH);
                    ring_mem[head_idx] = rq.data_word;
                    occupancy++;
                end
            end
            OP_POP_TAIL: begin
                if (occupancy == 0) begin
                    ans.status = ST_EMPTY_POP;
                end else begin
                    occupancy--;
                end
            end
            OP_POP_HEAD: begin
                if (occupancy == 0) begin
                    ans.status = ST_EMPTY_POP;
                end else begin
                    head_idx = PTR_BITS'((int'(head_idx) + 1) % DEPTH);
                    occupancy--;
                end
            end
            OP_READ: begin
                if (COUNT_BITS'(rq.position) >= occupancy) begin
                    ans.status = ST_RANGE;
                end else begin
                    slot = (int'(head_idx) + int'(rq.position)) % DEPTH;
                    ans.read_word = ring_mem[slot];
                end
            end
            default: ;
        endcase
        ans.count    = occupancy;
        ans.is_empty = (occupancy == 0);
        return ans;
    endfunction

    // Queue a request; track the fill level so reads can aim inside the deque
    task automatic queue_request(input logic [2:0] op, input logic signed [31:0] word,
                                 input logic [5:0] pos);
        t_deq_request rq;
        rq.opcode    = op;
        rq.data_word = word;
        rq.position  = pos;
        request_backlog.insert(request_backlog.size(), rq);
        if ((op == OP_PUSH_TAIL || op == OP_PUSH_HEAD) && gen_fill < DEPTH) begin
            gen_fill++;
        end else if ((op == OP_POP_TAIL || op == OP_POP_HEAD) && gen_fill > 0) begin
            gen_fill--;
        end
    endtask

    function automatic logic [2:0] pick_opcode(input t_mix_mode mode);
        int push_w;
        int pop_w;
        int r;
        case (mode)
            MODE_FILL:     begin push_w = 70; pop_w = 10; end
            MODE_DRAIN:    begin push_w = 10; pop_w = 70; end
            MODE_BALANCED: begin push_w = 40; pop_w = 37; end
            default:       begin push_w = 20; pop_w = 17; end
        endcase
        r = $urandom_range(0, 99);
        if (r < 3) begin
            return 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
        end
        r = r - 3;
        if (r < push_w) begin
            return $urandom_range(0, 1) ? OP_PUSH_TAIL : OP_PUSH_HEAD;
        end
        if (r < push_w + pop_w) begin
            return $urandom_range(0, 1) ? OP_POP_TAIL : OP_POP_HEAD;
        end
        return OP_READ;
    endfunction

    // Stimulus, reset and end of run
    initial begin
        t_mix_mode   mode_order [6];
        t_mix_mode   mode;
        int          block_left;
        int          block_no;
        logic [2:0]  op;
        logic [5:0]  pos;

        req_ch.valid     = 1'b0;
        req_ch.opcode    = OP_PUSH_TAIL;
        req_ch.data_word = '0;
        req_ch.position  = '0;
        rsp_ch.ready     = 1'b0;
        i_rst_n          = 1'b0;
        head_idx         = '0;
        occupancy        = '0;
        gen_fill         = 0;
        err_cnt          = 0;
        rsp_seen         = 0;
        hold_left        = 0;
        hold_done        = 1'b0;
        cyc              = 0;
        stall_cycles     = 0;

        // Directed: empty-queue errors, spare opcodes, word extremes, range edges
        queue_request(OP_READ, 32'sd0, 6'd0);
        queue_request(OP_POP_TAIL, 32'sd0, 6'd0);
        queue_request(OP_POP_HEAD, 32'sd0, 6'd0);
        for (int k = OP_SPARE_FIRST; k <= OP_SPARE_LAST; k++) begin
            queue_request(3'(k), $urandom(), 6'($urandom()));
        end
        queue_request(OP_PUSH_TAIL, 32'sh7FFF_FFFF, 6'd63);
        queue_request(OP_PUSH_HEAD, 32'sh8000_0000, 6'd0);
        queue_request(OP_PUSH_TAIL, -32'sd1, 6'd0);
        queue_request(OP_PUSH_HEAD, 32'sd0, 6'd0);
        queue_request(OP_READ, 32'sd0, 6'd0);
        queue_request(OP_READ, 32'sd0, 6'd3);
        queue_request(OP_READ, 32'sd0, 6'd4);
        queue_request(OP_READ, 32'sd0, 6'd63);
        queue_request(OP_POP_TAIL, 32'sd0, 6'd0);
        queue_request(OP_POP_HEAD, 32'sd0, 6'd0);
        queue_request(OP_READ, 32'sd0, 6'd1);
        queue_request(OP_POP_HEAD, 32'sd0, 6'd0);
        queue_request(OP_POP_TAIL, 32'sd0, 6'd0);
        queue_request(OP_READ, 32'sd0, 6'd0);
        queue_request(OP_PUSH_HEAD, 32'sd5, 6'd0);
        queue_request(OP_POP_TAIL, 32'sd0, 6'd0);
        queue_request(OP_PUSH_TAIL, $urandom(), 6'd0);
        queue_request(OP_POP_HEAD, 32'sd0, 6'd0);

        // Random: blocks that fill, read, and drain so full and empty both recur
        mode_order = '{MODE_FILL, MODE_FILL, MODE_READS, MODE_BALANCED,
                       MODE_DRAIN, MODE_DRAIN};
        block_no   = 0;
        block_left = 0;
        mode       = MODE_FILL;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (block_left == 0) begin
                mode       = mode_order[block_no % 6];
                block_no++;
                block_left = $urandom_range(40, 100);
            end
            block_left--;
            op  = pick_opcode(mode);
            pos = 6'($urandom());
            if (op == OP_READ && gen_fill > 0 && $urandom_range(0, 99) < 80) begin
                pos = 6'($urandom_range(0, gen_fill - 1));
            end
            queue_request(op, $urandom(), pos);
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Every request accepted, then every answer back
        @(negedge i_clk);
        while (request_backlog.size() != 0 || req_ch.valid) @(negedge i_clk);
        while (expected_answers.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (err_cnt == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Request driver: predicts on each accepted transaction
    always @(posedge i_clk) begin
        t_deq_request rq;
        bit           quiet;
        bit           idle;
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                rq.opcode    = req_ch.opcode;
                rq.data_word = req_ch.data_word;
                rq.position  = req_ch.position;
                expected_answers.insert(expected_answers.size(), deque_model_apply(rq));
            end
            if (!req_ch.valid || req_ch.ready) begin
                quiet = (cyc >= QUIET_FIRST && cyc < QUIET_LAST);
                idle  = !quiet && ($urandom_range(0, 99) < IDLE_PERCENT);
                if (request_backlog.size() != 0 && !idle) begin
                    rq = request_backlog[0];
                    request_backlog.delete(0);
                    req_ch.valid     <= 1'b1;
                    req_ch.opcode    <= rq.opcode;
                    req_ch.data_word <= rq.data_word;
                    req_ch.position  <= rq.position;
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // One long receiver hold-off, counted in cycles
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (!hold_done && rsp_seen >= HOLD_AT_RSP) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Response monitor and ready control
    always @(posedge i_clk) begin
        t_deq_answer want;
        bit          quiet;
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                rsp_seen++;
                if (expected_answers.size() == 0) begin
                    note_error("response transaction with none expected");
                end else begin
                    want = expected_answers[0];
                    expected_answers.delete(0);
                    if (rsp_ch.read_word !== want.read_word) begin
                        note_error($sformatf("read_word got %0d want %0d",
                                             rsp_ch.read_word, want.read_word));
                    end
                    if (rsp_ch.count !== want.count) begin
                        note_error($sformatf("count got %0d want %0d",
                                             rsp_ch.count, want.count));
                    end
                    if (rsp_ch.is_empty !== want.is_empty) begin
                        note_error($sformatf("is_empty got %0b want %0b",
                                             rsp_ch.is_empty, want.is_empty));
                    end
                    if (rsp_ch.status !== want.status) begin
                        note_error($sformatf("status got %0d want %0d",
                                             rsp_ch.status, want.status));
                    end
                end
            end
            quiet = (cyc >= QUIET_FIRST && cyc < QUIET_LAST);
            if (hold_left > 0) begin
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= quiet || ($urandom_range(0, 99) >= IDLE_PERCENT);
            end
        end
    end

    // Watchdog on cycles with no transaction on either channel
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

endmodule
